// ===== design/wsic_pkg.sv =====
package wsic_pkg;

  localparam int WINDOW     = 10;
  localparam int DUTY_MAX   = 14998;
  localparam int DUTY_RESET = 3750;

  localparam int PERIOD_W   = 16;
  localparam int SUM_W      = 20;
  localparam int SPEED_W    = 16;
  localparam int DUTY_W     = 14;
  localparam int TGT_W      = 8;
  localparam int STEP_W     = 10;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 64;

  localparam int TARGET_RESET = 50;
  localparam int BAND_RESET   = 3;
  localparam int STEP_RESET   = 100;

  // sample counter inside one window
  localparam int CNT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  // floor(sum / WINDOW) as (sum * REC) >> REC_SH, exact for any SUM_W-bit sum
  localparam int REC_SH = 25;
  localparam int REC    = (2**REC_SH + WINDOW - 1) / WINDOW;
  localparam int REC_W  = REC_SH + 1;
  localparam int PROD_W = SUM_W + REC_W;

  localparam int SPEED_SCALE = 2000000;
  localparam int DIV_W       = $clog2(SPEED_SCALE + 1);
  localparam int DIVCNT_W    = $clog2(DIV_W + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_LEFT  = 8'd0,
    REG_TARGET_RIGHT = 8'd1,
    REG_DEADBAND     = 8'd2,
    REG_DUTY_STEP    = 8'd3
  } reg_idx_t;

  typedef struct packed {
    logic win_end;
    logic avg_zero;
    logic div_last;
  } sts_t;

  typedef struct packed {
    logic acc;
    logic avg;
    logic div_init;
    logic div_step;
    logic store;
    logic side;
    logic load;
  } cmd_t;

endpackage

// ===== design/wsic_ctrl.sv =====
module wsic_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            out_ready,
  output logic            out_valid,
  input  wsic_pkg::sts_t  sts,
  output wsic_pkg::cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_AVG  = 6'b000010,
    S_INIT = 6'b000100,
    S_DIV  = 6'b001000,
    S_END  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   side_r, side_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    side_nxt  = side_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.side  = side_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.acc = 1'b1;
          if (sts.win_end) begin
            state_nxt = S_AVG;
            side_nxt  = 1'b0;
          end
        end
      end
      S_AVG: begin
        cmd.avg   = 1'b1;
        state_nxt = S_INIT;
      end
      S_INIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = sts.avg_zero ? S_END : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_END;
      end
      S_END: begin
        cmd.store = 1'b1;
        if (side_r) begin
          state_nxt = S_OUT;
        end else begin
          side_nxt  = 1'b1;
          state_nxt = S_AVG;
        end
      end
      S_OUT: begin
        // wait for the output slot to free up
        if (!out_valid_r || out_ready) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (cmd.load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      side_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      side_r      <= side_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (!out_valid_r || out_ready))
    else $error("result loaded over a pending item");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> out_valid_r)
    else $error("loaded result not presented");

  a_win_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && sts.win_end) |=> (state_r == S_AVG && !side_r))
    else $error("window end did not start the left wheel");

  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && sts.div_last) |=> (state_r == S_END))
    else $error("divider did not finish");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready)
    else $error("input taken while computing");

endmodule

// ===== design/wsic_dp.sv =====
module wsic_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [wsic_pkg::IN_DATA_W-1:0]      in_data,
  input  logic                                cfg_valid,
  input  logic [wsic_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wsic_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wsic_pkg::cmd_t                      cmd,
  output wsic_pkg::sts_t                      sts,
  output logic [wsic_pkg::OUT_DATA_W-1:0]     out_data
);

  localparam int SW = wsic_pkg::SUM_W;
  localparam int PW = wsic_pkg::PERIOD_W;
  localparam int VW = wsic_pkg::SPEED_W;
  localparam int DW = wsic_pkg::DUTY_W;
  localparam int QW = wsic_pkg::DIV_W;
  localparam int PAD_W = wsic_pkg::OUT_DATA_W - 2*VW - 2*DW;

  logic [wsic_pkg::TGT_W-1:0]   tgt_l_r, tgt_r_r, band_r;
  logic [wsic_pkg::STEP_W-1:0]  step_r;

  logic [SW-1:0]                lsum_r, rsum_r;
  logic [wsic_pkg::CNT_W-1:0]   cnt_r;
  logic [wsic_pkg::PROD_W-1:0]  prod_r;
  logic [QW-1:0]                num_r;
  logic [SW-1:0]                rem_r;
  logic [wsic_pkg::DIVCNT_W-1:0] dcnt_r;
  logic [VW-1:0]                lspd_r, rspd_r, out_lspd_r, out_rspd_r;
  logic [DW-1:0]                lduty_r, rduty_r;

  logic [SW-1:0]  sum_sel, avg;
  logic [SW:0]    trial, div_ext;
  logic           ge;
  logic [VW-1:0]  spd_sat;
  logic [DW-1:0]  lduty_new, rduty_new;

  function automatic logic [DW-1:0] adjust(
    input logic [DW-1:0]                duty,
    input logic [VW-1:0]                speed,
    input logic [wsic_pkg::TGT_W-1:0]   target,
    input logic [wsic_pkg::TGT_W-1:0]   band,
    input logic [wsic_pkg::STEP_W-1:0]  step
  );
    logic [VW:0] hi;
    logic [VW:0] spd_band;
    logic [DW:0] up;
    logic [DW-1:0] res;
    hi       = (VW+1)'(target) + (VW+1)'(band);
    spd_band = (VW+1)'(speed) + (VW+1)'(band);
    up       = (DW+1)'(duty) + (DW+1)'(step);
    res      = duty;
    if (((VW+1)'(speed) > hi) && (duty > DW'(step)))
      res = duty - DW'(step);
    else if ((spd_band < (VW+1)'(target)) && (up < (DW+1)'(wsic_pkg::DUTY_MAX)))
      res = up[DW-1:0];
    return res;
  endfunction

  assign sum_sel = cmd.side ? rsum_r : lsum_r;
  assign avg     = prod_r[wsic_pkg::REC_SH +: SW];
  assign div_ext = {1'b0, avg};
  assign trial   = {rem_r, num_r[QW-1]};
  assign ge      = (trial >= div_ext);
  assign spd_sat = (|num_r[QW-1:VW]) ? {VW{1'b1}} : num_r[VW-1:0];

  assign lduty_new = adjust(lduty_r, lspd_r, tgt_l_r, band_r, step_r);
  assign rduty_new = adjust(rduty_r, rspd_r, tgt_r_r, band_r, step_r);

  assign sts.win_end  = (cnt_r == wsic_pkg::CNT_W'(wsic_pkg::WINDOW - 1));
  assign sts.avg_zero = (avg == '0);
  assign sts.div_last = (dcnt_r == wsic_pkg::DIVCNT_W'(1));

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_l_r <= wsic_pkg::TGT_W'(wsic_pkg::TARGET_RESET);
      tgt_r_r <= wsic_pkg::TGT_W'(wsic_pkg::TARGET_RESET);
      band_r  <= wsic_pkg::TGT_W'(wsic_pkg::BAND_RESET);
      step_r  <= wsic_pkg::STEP_W'(wsic_pkg::STEP_RESET);
    end else if (cfg_valid) begin
      case (cfg_index)
        wsic_pkg::REG_TARGET_LEFT:  tgt_l_r <= cfg_data[wsic_pkg::TGT_W-1:0];
        wsic_pkg::REG_TARGET_RIGHT: tgt_r_r <= cfg_data[wsic_pkg::TGT_W-1:0];
        wsic_pkg::REG_DEADBAND:     band_r  <= cfg_data[wsic_pkg::TGT_W-1:0];
        wsic_pkg::REG_DUTY_STEP:    step_r  <= cfg_data[wsic_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // window accumulation and duty state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lsum_r  <= '0;
      rsum_r  <= '0;
      cnt_r   <= '0;
      lduty_r <= DW'(wsic_pkg::DUTY_RESET);
      rduty_r <= DW'(wsic_pkg::DUTY_RESET);
    end else if (cmd.acc) begin
      lsum_r <= lsum_r + SW'(in_data[PW-1:0]);
      rsum_r <= rsum_r + SW'(in_data[2*PW-1:PW]);
      cnt_r  <= sts.win_end ? '0 : cnt_r + 1'b1;
    end else if (cmd.load) begin
      lsum_r  <= '0;
      rsum_r  <= '0;
      lduty_r <= lduty_new;
      rduty_r <= rduty_new;
    end
  end

  // average, restoring divider, speed capture
  always_ff @(posedge clk) begin
    if (cmd.avg)
      prod_r <= wsic_pkg::PROD_W'(sum_sel) * wsic_pkg::PROD_W'(wsic_pkg::REC);
    if (cmd.div_init) begin
      // zero average forces a saturated quotient
      num_r  <= sts.avg_zero ? {QW{1'b1}} : QW'(wsic_pkg::SPEED_SCALE);
      rem_r  <= '0;
      dcnt_r <= wsic_pkg::DIVCNT_W'(QW);
    end else if (cmd.div_step) begin
      rem_r  <= ge ? SW'(trial - div_ext) : trial[SW-1:0];
      num_r  <= {num_r[QW-2:0], ge};
      dcnt_r <= dcnt_r - 1'b1;
    end
    if (cmd.store) begin
      if (cmd.side) rspd_r <= spd_sat;
      else          lspd_r <= spd_sat;
    end
    if (cmd.load) begin
      out_lspd_r <= lspd_r;
      out_rspd_r <= rspd_r;
    end
  end

  assign out_data = {{PAD_W{1'b0}}, rduty_r, lduty_r, out_rspd_r, out_lspd_r};

endmodule

// ===== design/wheel_speed_incremental_control.sv =====
// Wheel speed controller with incremental duty update.
// in_*  : one item per tachometer sample, both wheel periods in in_tdata.
// cfg_* : register writes (index 0 left target, 1 right target, 2 deadband,
//         3 duty step); cfg_ready is always high.
// out_* : one item per window of WINDOW samples with speeds and new duties.
// Samples inside a window are accepted back to back. The last sample of a
// window starts the update: per wheel the average multiply, a setup step,
// the shared bit-serial divider and a store step; then the result is loaded
// into the output register, raising out_tvalid. in_tready is low throughout
// the update. The divider is skipped for a zero average.
// The result sits in an output register; samples of the next window are
// taken while it waits. When the receiver stalls and the next window ends,
// the update finishes and then holds until the pending item is taken.
// Reset (rst_n low, synchronous) restores the register defaults, clears the
// sums and sample count, sets both duties to 3750 and drops out_tvalid.
module wheel_speed_incremental_control (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // left_period[15:0], right_period[31:16]
  input  logic [wsic_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // left_speed[15:0], right_speed[31:16], left_drive[45:32], right_drive[59:46]
  output logic [wsic_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wsic_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wsic_pkg::CFG_DATA_W-1:0]     cfg_data
);

  wsic_pkg::cmd_t cmd;
  wsic_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  wsic_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .sts       (sts),
    .cmd       (cmd)
  );

  wsic_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_tdata)
  );

endmodule
